>>> rtl/sitda_pkg.sv
package sitda_pkg;

  // one ascii character
  typedef logic [7:0] char_t;

  localparam char_t DIGIT_BASE = 8'd48;  // '0'
  localparam char_t DIGIT_NINE = 8'd57;  // '9'
  localparam char_t MINUS_CHAR = 8'd45;  // '-'

endpackage

>>> rtl/sitda_dabble.sv
// one shift-add-3 step: add 3 to every bcd digit of 5 or more, then shift in the next binary bit
module sitda_dabble #(
  parameter int NDIG = 10
) (
  input  logic [4*NDIG-1:0] bcd,
  input  logic              bit_in,
  output logic [4*NDIG-1:0] bcd_next
);

  logic [4*NDIG-1:0] adj;

  always_comb begin
    adj = bcd;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[4*NDIG-2:0], bit_in};
  end

endmodule

>>> rtl/sitda_out_reg.sv
// single output register between the sequencer and the character channel
module sitda_out_reg
  import sitda_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  char_t push_char,
  input  logic  push_last,
  output logic  free,
  output logic  char_valid,
  input  logic  char_ready,
  output char_t ascii_char,
  output logic  last
);

  assign free = !char_valid || char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (free) begin
      char_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      ascii_char <= push_char;
      last       <= push_last;
    end
  end

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ascii text. Each item on the value channel is a
// two's complement integer of VALUE_BITS bits; the block sends its decimal
// text one character per item on the char channel, most significant first,
// with a leading '-' for negative values and no leading zeros (zero gives a
// single '0'). The most negative value prints through its true magnitude.
// The final character of each number carries last = 1. For each item the
// block takes the item and forms its magnitude, shifts the magnitude msb
// first through the shared shift-add-3 unit (one binary bit per cycle),
// then puts out the sign if negative, then walks the decimal positions, one
// per cycle, where leading zero positions are skipped without output and a
// digit or the sign waits while the output register is full. value_ready is
// high only between numbers; a finished character waits in the output
// register, so the next number can be taken while the last character of the
// previous one is still held.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         value_valid,
  output logic                         value_ready,
  output char_t                        ascii_char,
  output logic                         last,
  output logic                         char_valid,
  input  logic                         char_ready
);

  // decimal positions needed for VALUE_BITS of magnitude
  localparam int NDIG     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS = 4 * NDIG;
  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
  localparam int REM_BITS = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag;       // magnitude, shifted out msb first
  logic                  neg;
  logic [BCD_BITS-1:0]   bcd;       // decimal digits being built
  logic [BCD_BITS-1:0]   bcd_next;
  logic [CNT_BITS-1:0]   cnt;       // binary bits still to shift in
  logic [REM_BITS-1:0]   rem;       // decimal positions still to walk
  logic                  started;   // a nonzero digit has gone out
  logic [3:0]            top_digit;
  logic                  skip;
  logic                  out_free;
  logic                  push;
  char_t                 push_char;
  logic                  push_last;

  assign value_u     = $unsigned(value);
  assign value_ready = (state == ST_IDLE);
  assign top_digit   = bcd[BCD_BITS-1 -: 4];

  // leading zero position: drop it, except the units position
  assign skip = !started && (top_digit == 4'd0) && (rem != REM_BITS'(1));

  // shared shift-add-3 unit
  sitda_dabble #(
    .NDIG(NDIG)
  ) u_dabble (
    .bcd     (bcd),
    .bit_in  (mag[VALUE_BITS-1]),
    .bcd_next(bcd_next)
  );

  sitda_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_char (push_char),
    .push_last (push_last),
    .free      (out_free),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .ascii_char(ascii_char),
    .last      (last)
  );

  // character offered to the output register
  always_comb begin
    push      = 1'b0;
    push_char = DIGIT_BASE + {4'b0000, top_digit};
    push_last = (rem == REM_BITS'(1));
    case (state)
      ST_SIGN: begin
        push      = neg && out_free;
        push_char = MINUS_CHAR;
        push_last = 1'b0;
      end
      ST_EMIT: begin
        push = out_free && !skip;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (value_valid) begin
            neg   <= value_u[VALUE_BITS-1];
            mag   <= value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;
            bcd   <= '0;
            cnt   <= CNT_BITS'(VALUE_BITS);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd <= bcd_next;
          mag <= mag << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_BITS'(1)) begin
            state <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          // sign goes out first when negative
          if (!neg || out_free) begin
            rem     <= REM_BITS'(NDIG);
            started <= 1'b0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip || push) begin
            bcd <= bcd << 4;
            rem <= rem - 1'b1;
            if (push) begin
              started <= 1'b1;
            end
            if (rem == REM_BITS'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a taken number keeps the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (value_valid && value_ready) |=> !value_ready)
    else $error("ready right after taking a number");

  // only '-' or a decimal digit leaves the block
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (ascii_char == MINUS_CHAR ||
                    (ascii_char >= DIGIT_BASE && ascii_char <= DIGIT_NINE)))
    else $error("illegal character on output");

  // the sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && ascii_char == MINUS_CHAR) |-> !last)
    else $error("minus sign flagged as last");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sitda_pkg::*;

  localparam int          VALUE_BITS   = 32;
  localparam int          RADIX        = 10;
  localparam int          RANDOM_ITEMS = 360;
  // receiver hold-off: starts after this many chars, lasts this many cycles
  localparam int          HOLD_AT      = 1200;
  localparam int          HOLD_CYCLES  = 400;
  // cycles with no accepted item on either channel before giving up
  localparam int          STALL_LIMIT  = 2000;
  // settle time after the last char, well past one conversion
  localparam int          TAIL_CYCLES  = 60;
  localparam int          SHOWN_ERRORS = 10;

  // one expected char of the decimal text
  typedef struct packed {
    char_t code;
    logic  is_last;
  } text_char_t;

  logic                         clk;
  logic                         rst;
  logic signed [VALUE_BITS-1:0] value;
  logic                         value_valid;
  logic                         value_ready;
  char_t                        ascii_char;
  logic                         last;
  logic                         char_valid;
  logic                         char_ready;

  text_char_t   pending_chars[$];
  int           mismatches;
  int           chars_seen;
  bit           send_calm;
  bit           recv_calm;
  logic [31:0]  row_value[$];
  string        row_text[$];

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .value_valid(value_valid),
    .value_ready(value_ready),
    .ascii_char (ascii_char),
    .last       (last),
    .char_valid (char_valid),
    .char_ready (char_ready)
  );

  // 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // decimal text of one integer, pushed char by char, most significant first
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[0:19];
    int                    count;
    text_char_t            c;
    begin
      // two's complement negate; the most negative value keeps its bits,
      // which read unsigned is its true magnitude
      mag   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
      count = 0;
      do begin
        digits[count] = 4'(mag % RADIX);
        mag           = mag / RADIX;
        count++;
      end while (mag != 0);
      if (raw[VALUE_BITS-1]) begin
        c.code    = MINUS_CHAR;
        c.is_last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int k = count - 1; k >= 0; k--) begin
        c.code    = DIGIT_BASE + char_t'(digits[k]);
        c.is_last = (k == 0);
        pending_chars.push_back(c);
      end
    end
  endfunction

  // expected text typed in by hand
  function automatic void queue_typed_text(input string s);
    text_char_t c;
    begin
      for (int i = 0; i < s.len(); i++) begin
        c.code    = char_t'(s[i]);
        c.is_last = (i == s.len() - 1);
        pending_chars.push_back(c);
      end
    end
  endfunction

  function automatic void add_row(input logic [31:0] v, input string s);
    row_value.push_back(v);
    row_text.push_back(s);
  endfunction

  // wait cycles for the next item, with calm stretches of no idling
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(19, 0) == 0)
      calm = !calm;
    return calm ? 0 : int'($urandom_range(17, 0));
  endfunction

  function automatic logic [31:0] pow10(input int k);
    logic [31:0] p;
    begin
      p = 1;
      repeat (k) p = p * RADIX;
      return p;
    end
  endfunction

  // random integer: full range, given digit count, near powers of ten, tiny
  function automatic logic [31:0] pick_value();
    int          ndig;
    logic [31:0] mag;
    logic [31:0] lo;
    logic [31:0] hi;
    bit          neg;
    begin
      neg = 1'($urandom_range(1, 0));
      case ($urandom_range(3, 0))
        0: return $urandom();
        1: begin
          ndig = $urandom_range(10, 1);
          lo   = (ndig == 1) ? 32'd0 : pow10(ndig - 1);
          hi   = (ndig == 10) ? 32'h7fff_ffff : pow10(ndig) - 1;
          mag  = $urandom_range(hi, lo);
          if (neg && ndig == 10 && $urandom_range(7, 0) == 0)
            mag = 32'h8000_0000;
        end
        2: mag = pow10($urandom_range(9, 0)) + $urandom_range(2, 0) - 1;
        default: mag = $urandom_range(99, 0);
      endcase
      return neg ? -mag : mag;
    end
  endfunction

  // offer one item, record its text once it is taken
  task automatic send_item(input logic [31:0] v, input string typed);
    int gap;
    begin
      gap = draw_gap(send_calm);
      if (gap > 0) begin
        value_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      value       <= v;
      value_valid <= 1'b1;
      do @(posedge clk); while (!(value_valid && value_ready));
      if (typed.len() > 0)
        queue_typed_text(typed);
      else
        queue_decimal_text(v);
      @(negedge clk);
    end
  endtask

  // char channel checker
  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (!rst && char_valid && char_ready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected char: got %0d last %0b", ascii_char, last);
      end else begin
        want = pending_chars.pop_front();
        if (ascii_char !== want.code || last !== want.is_last) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("char mismatch: expected %0d last %0b, got %0d last %0b",
                     want.code, want.is_last, ascii_char, last);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin : receiver
    int gap;
    char_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (chars_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(recv_calm);
      if (gap > 0) begin
        char_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      char_ready <= 1'b1;
      do @(posedge clk); while (!(char_valid && char_ready));
      @(negedge clk);
    end
  end

  // watchdog on cycles with no item moving
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((value_valid && value_ready) || (char_valid && char_ready) || rst)
        idle = 0;
      else
        idle++;
    end
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

  initial begin : sender
    rst         = 1'b1;
    value       = '0;
    value_valid = 1'b0;
    mismatches  = 0;
    chars_seen  = 0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows; empty text means the predictor decides
    add_row(32'd0, "0");
    add_row(32'd1, "1");
    add_row(-32'sd1, "-1");
    add_row(32'd9, "9");
    add_row(32'd10, "10");
    add_row(-32'sd10, "-10");
    add_row(32'd99, "99");
    add_row(32'd100, "100");
    add_row(32'd999_999_999, "999999999");
    add_row(32'd1_000_000_000, "1000000000");
    add_row(-32'sd1_000_000_000, "-1000000000");
    add_row(32'h7fff_ffff, "2147483647");
    add_row(32'h8000_0000, "-2147483648");   // most negative value
    add_row(32'h8000_0001, "-2147483647");
    add_row(32'd0, "0");                     // zero right after a long number
    add_row(32'h5555_5555, "");
    add_row(32'haaaa_aaaa, "");
    add_row(32'h0f0f_0f0f, "");
    add_row(32'hf0f0_f0f0, "");
    add_row(32'd123_456_789, "");
    add_row(-32'sd987_654_321, "");
    add_row(32'd1_000_000_001, "");
    foreach (row_value[i])
      send_item(row_value[i], row_text[i]);

    repeat (RANDOM_ITEMS)
      send_item(pick_value(), "");
    value_valid <= 1'b0;

    // drain, then give the block time to show any extra char
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_chars.size() == 0)
      $display("signed_int_to_decimal_ascii regression: pass");
    else
      $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule
